@@ design/srsa_pkg.sv @@
// Package for the sorted sparse row accumulator.
// Holds request kinds, status codes, sequencer states and saturation helpers.
// No dependencies.
package srsa_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int INDEX_BITS_DEF = 16;

    typedef enum logic [2:0] {
        KIND_ADD   = 3'd0,
        KIND_SUB   = 3'd1,
        KIND_REM   = 3'd2,
        KIND_SCALE = 3'd3,
        KIND_READ  = 3'd4,
        KIND_DUMP  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_INS,
        S_SHIFT_DN,
        S_SCALE,
        S_DUMP,
        S_POST
    } state_t;

    // Clamp a 33-bit sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
        logic signed [31:0] r;
        if (x[32] != x[31])
            r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            r = x[31:0];
        return r;
    endfunction

    // Round a Q32.32 product half up to Q16.16 and clamp.
    function automatic logic signed [31:0] round_sat(input logic signed [63:0] p);
        logic signed [63:0] t;
        logic signed [63:0] q;
        logic signed [31:0] r;
        t = p + 64'sd32768;
        q = t >>> 16;
        if (q[63:31] == '0 || q[63:31] == '1)
            r = q[31:0];
        else
            r = q[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        return r;
    endfunction

endpackage

@@ design/sorted_sparse_row_accumulator_top.sv @@
// Sorted sparse row accumulator: one sparse row held as (column, value)
// entries in column order inside a single synchronous memory.
// Depends on srsa_pkg.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   request | in_valid, in_ready, kind, col_index, value | in
//   result  | out_valid, out_ready, entry_index,          | out
//           | entry_value, status, last                  |
//
// Add, subtract, read and remove scan one entry a cycle up to the target
// column, then an insert or remove shifts the tail one entry a cycle, all
// bounded by the one read and one write port. Scale rewrites one entry a cycle; dump
// emits one result a cycle while the result register is free to take it.
// Reset clears the entry count and control state only; memory contents stay
// undefined and are never read below an unwritten entry. No clearing pass.
// A stalled result register holds the sequencer before it posts the next
// result; a new request is taken while the last result still waits.
module sorted_sparse_row_accumulator_top #(
    parameter int CAPACITY   = srsa_pkg::CAPACITY_DEF,
    parameter int INDEX_BITS = srsa_pkg::INDEX_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [15:0] col_index,
    input  logic signed [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] entry_index,
    output logic signed [31:0] entry_value,
    output logic [1:0]  status,
    output logic        last
);
    import srsa_pkg::*;

    localparam int COL_W = (INDEX_BITS < 16) ? INDEX_BITS : 16;
    localparam int AW    = $clog2(CAPACITY);
    localparam int PW    = $clog2(CAPACITY + 1);
    localparam int MW    = COL_W + 32;
    localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

    // Entry memory: column in the high bits, Q16.16 value in the low bits.
    logic [MW-1:0] mem [CAPACITY];
    logic [MW-1:0] rd_q;
    logic          we;
    logic [AW-1:0] wa;
    logic [MW-1:0] wd;
    logic [AW-1:0] rd_addr;

    state_t state_reg, state_next;
    logic [2:0]       kind_reg, kind_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic signed [31:0] val_reg, val_next;
    logic [PW-1:0]    ptr_reg, ptr_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [PW-1:0]    count_reg, count_next;
    logic [15:0]      res_idx_reg, res_idx_next;
    logic signed [31:0] res_val_reg, res_val_next;
    logic [1:0]       res_st_reg, res_st_next;

    // Scale pipeline: product register ahead of the rounding write.
    logic signed [63:0] prod_reg;
    logic [AW-1:0]      paddr_reg;
    logic [COL_W-1:0]   pcol_reg;
    logic               pvalid_reg, pvalid_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_idx_reg, out_idx_next;
    logic signed [31:0] out_val_reg, out_val_next;
    logic [1:0]  out_st_reg, out_st_next;
    logic        out_last_reg, out_last_next;

    logic [COL_W-1:0]   rd_col;
    logic signed [31:0] rd_val;
    logic               in_acc;
    logic               out_free;
    logic               in_range;
    logic               scan_more;
    logic               hit;
    logic               cap_full;
    logic signed [31:0] upd_val;
    logic signed [31:0] ins_val;
    logic [15:0]        col_ext;
    logic [PW-1:0]      ptr_inc;
    logic [PW-1:0]      ptr_dec;
    logic [PW-1:0]      cnt_dec;

    assign rd_col    = rd_q[MW-1:32];
    assign rd_val    = rd_q[31:0];
    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_range  = ptr_reg < count_reg;
    assign scan_more = in_range && (rd_col < col_reg);
    assign hit       = in_range && (rd_col == col_reg);
    assign cap_full  = (count_reg == CAP_P);
    assign col_ext   = 16'(col_reg);
    assign ptr_inc   = ptr_reg + 1'b1;
    assign ptr_dec   = ptr_reg - 1'b1;
    assign cnt_dec   = count_reg - 1'b1;
    assign upd_val   = (kind_reg == KIND_SUB)
                     ? sat33({rd_val[31], rd_val} - {val_reg[31], val_reg})
                     : sat33({rd_val[31], rd_val} + {val_reg[31], val_reg});
    always_comb
    begin
        case (kind_reg)
            KIND_ADD: ins_val = val_reg;
            KIND_SUB: ins_val = sat33(33'sd0 - {val_reg[31], val_reg});
            default:  ins_val = '0;
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign entry_index = out_idx_reg;
    assign entry_value = out_val_reg;
    assign status      = out_st_reg;
    assign last        = out_last_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (kind) inside
                        KIND_ADD, KIND_SUB, KIND_REM, KIND_READ: state_next = S_SCAN;
                        KIND_SCALE: state_next = S_SCALE;
                        KIND_DUMP:  state_next = (count_reg == '0) ? S_POST : S_DUMP;
                        default:    state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!scan_more)
                begin
                    if (kind_reg == KIND_REM)
                        state_next = hit ? S_SHIFT_DN : S_POST;
                    else if (hit || cap_full)
                        state_next = S_POST;
                    else if (ptr_reg == count_reg)
                        state_next = S_INS;
                    else
                        state_next = S_SHIFT_UP;
                end
            end
            S_SHIFT_UP: if (ptr_reg == pos_reg) state_next = S_INS;
            S_INS:      state_next = S_POST;
            S_SHIFT_DN: if (!in_range) state_next = S_POST;
            S_SCALE:    if (!in_range) state_next = S_POST;
            S_DUMP:     if (out_free && ptr_reg == cnt_dec) state_next = S_IDLE;
            S_POST:     if (out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath, memory port and result control.
    always_comb
    begin
        kind_next      = kind_reg;
        col_next       = col_reg;
        val_next       = val_reg;
        ptr_next       = ptr_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        res_idx_next   = res_idx_reg;
        res_val_next   = res_val_reg;
        res_st_next    = res_st_reg;
        pvalid_next    = 1'b0;
        we             = 1'b0;
        wa             = ptr_reg[AW-1:0];
        wd             = rd_q;
        out_valid_next = out_valid_reg && !out_ready;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;
        out_st_next    = out_st_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    kind_next    = kind;
                    col_next     = col_index[COL_W-1:0];
                    val_next     = value;
                    ptr_next     = '0;
                    res_idx_next = '0;
                    res_val_next = '0;
                    res_st_next  = (kind == KIND_DUMP && count_reg == '0) ? ST_EMPTY : ST_OK;
                end
            end
            S_SCAN:
            begin
                if (scan_more)
                    ptr_next = ptr_inc;
                else
                begin
                    pos_next = ptr_reg;
                    if (kind_reg == KIND_REM)
                        ptr_next = ptr_inc;
                    else if (hit)
                    begin
                        if (kind_reg == KIND_READ)
                        begin
                            res_idx_next = col_ext;
                            res_val_next = rd_val;
                        end
                        else
                        begin
                            we           = 1'b1;
                            wd           = {col_reg, upd_val};
                            res_val_next = upd_val;
                        end
                    end
                    else if (cap_full)
                    begin
                        res_st_next  = ST_FULL;
                        res_idx_next = (kind_reg == KIND_READ) ? col_ext : '0;
                    end
                    else
                        ptr_next = cnt_dec;
                end
            end
            S_SHIFT_UP:
            begin
                we = 1'b1;
                wa = ptr_inc[AW-1:0];
                if (ptr_reg != pos_reg)
                    ptr_next = ptr_dec;
            end
            S_INS:
            begin
                we           = 1'b1;
                wa           = pos_reg[AW-1:0];
                wd           = {col_reg, ins_val};
                count_next   = count_reg + 1'b1;
                res_val_next = ins_val;
                res_idx_next = (kind_reg == KIND_READ) ? col_ext : '0;
            end
            S_SHIFT_DN:
            begin
                if (in_range)
                begin
                    we       = 1'b1;
                    wa       = ptr_dec[AW-1:0];
                    ptr_next = ptr_inc;
                end
                else
                    count_next = cnt_dec;
            end
            S_SCALE:
            begin
                pvalid_next = in_range;
                if (in_range)
                    ptr_next = ptr_inc;
                if (pvalid_reg)
                begin
                    we = 1'b1;
                    wa = paddr_reg;
                    wd = {pcol_reg, round_sat(prod_reg)};
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = 16'(rd_col);
                    out_val_next   = rd_val;
                    out_st_next    = ST_OK;
                    out_last_next  = (ptr_reg == cnt_dec);
                    if (ptr_reg != cnt_dec)
                        ptr_next = ptr_inc;
                end
            end
            S_POST:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = res_idx_reg;
                    out_val_next   = res_val_reg;
                    out_st_next    = res_st_reg;
                    out_last_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign rd_addr = ptr_next[AW-1:0];

    // Read the entry the sequencer visits next; write back one entry a cycle.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_q <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pvalid_reg    <= pvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        col_reg      <= col_next;
        val_reg      <= val_next;
        ptr_reg      <= ptr_next;
        pos_reg      <= pos_next;
        res_idx_reg  <= res_idx_next;
        res_val_reg  <= res_val_next;
        res_st_reg   <= res_st_next;
        out_idx_reg  <= out_idx_next;
        out_val_reg  <= out_val_next;
        out_st_reg   <= out_st_next;
        out_last_reg <= out_last_next;
        prod_reg     <= rd_val * val_reg;
        paddr_reg    <= ptr_reg[AW-1:0];
        pcol_reg     <= rd_col;
    end

    // The table never holds more entries than it has room for.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_P)
        else $error("entry count above capacity");

    // The memory is written only while a request is in progress.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> state_reg != S_IDLE)
        else $error("memory write while idle");

    // The entry count moves by at most one per cycle.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) && count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + 1'b1 || count_reg == $past(count_reg) - 1'b1))
        else $error("entry count jumped");

    // A result posted while the output is stalled would be lost.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && (state_reg == S_POST || state_reg == S_DUMP)
            |=> $stable(out_idx_reg) && $stable(out_val_reg))
        else $error("result overwritten while stalled");

endmodule

@@ dv/tb_sorted_sparse_row_accumulator_top.sv @@
// Self-checking testbench for the sorted sparse row accumulator.
// Drives add, subtract, remove, scale, read and dump requests and predicts each result.
// Depends on srsa_pkg and sorted_sparse_row_accumulator_top.
`timescale 1ns / 100ps

module tb_sorted_sparse_row_accumulator_top;
    import srsa_pkg::*;

    localparam int ROW_CAP = 64;

    typedef struct packed {
        logic [15:0]        col;
        logic signed [31:0] val;
        logic [1:0]         st;
        logic               lst;
    } row_result_t;

    // Row predictor and queue of the results it has worked out so far.
    class row_scoreboard;
        logic [15:0]        cols[ROW_CAP];
        logic signed [31:0] vals[ROW_CAP];
        int                 count;
        row_result_t        pending[$];
        int                 mismatches;

        function new();
            count = 0;
            mismatches = 0;
        endfunction

        function logic signed [31:0] clamp(input logic signed [63:0] x);
            logic signed [31:0] r;
            if (x > 64'sh7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (x < -64'sh8000_0000)
                r = 32'sh8000_0000;
            else
                r = x[31:0];
            return r;
        endfunction

        function logic signed [31:0] fixmul(input logic signed [31:0] a,
                                            input logic signed [31:0] b);
            logic signed [63:0] t;
            t = 64'(a) * 64'(b) + 64'sd32768;
            return clamp(t >>> 16);
        endfunction

        // Slot of col; -1 if a full row drops the insert; -2 - p if col is absent and grow is 0.
        function int find_slot(input logic [15:0] col, input bit grow);
            int p;
            p = 0;
            while (p < count && cols[p] < col)
                p++;
            if (p < count && cols[p] == col)
                return p;
            if (!grow)
                return -2 - p;
            if (count >= ROW_CAP)
                return -1;
            for (int i = count; i > p; i--)
            begin
                cols[i] = cols[i-1];
                vals[i] = vals[i-1];
            end
            cols[p] = col;
            vals[p] = '0;
            count++;
            return p;
        endfunction

        function void push(input logic [15:0] c, input logic signed [31:0] v,
                           input status_t s, input bit l);
            row_result_t r;
            r.col = c;
            r.val = v;
            r.st  = s;
            r.lst = l;
            pending.push_back(r);
        endfunction

        function void note_request(input logic [2:0] k, input logic [15:0] col,
                                   input logic signed [31:0] v);
            int p;
            case (k)
                KIND_ADD, KIND_SUB:
                begin
                    p = find_slot(col, 1);
                    if (p < 0)
                        push('0, '0, ST_FULL, 1);
                    else
                    begin
                        vals[p] = (k == KIND_ADD) ? clamp(64'(vals[p]) + 64'(v))
                                                  : clamp(64'(vals[p]) - 64'(v));
                        push('0, vals[p], ST_OK, 1);
                    end
                end
                KIND_REM:
                begin
                    p = find_slot(col, 0);
                    if (p >= 0)
                    begin
                        for (int i = p; i < count - 1; i++)
                        begin
                            cols[i] = cols[i+1];
                            vals[i] = vals[i+1];
                        end
                        count--;
                    end
                    push('0, '0, ST_OK, 1);
                end
                KIND_SCALE:
                begin
                    for (int i = 0; i < count; i++)
                        vals[i] = fixmul(vals[i], v);
                    push('0, '0, ST_OK, 1);
                end
                KIND_READ:
                begin
                    p = find_slot(col, 1);
                    if (p < 0)
                        push(col, '0, ST_FULL, 1);
                    else
                        push(col, vals[p], ST_OK, 1);
                end
                KIND_DUMP:
                begin
                    if (count == 0)
                        push('0, '0, ST_EMPTY, 1);
                    for (int i = 0; i < count; i++)
                        push(cols[i], vals[i], ST_OK, i == count - 1);
                end
                default: ;
            endcase
        endfunction

        function void check_result(input row_result_t got);
            row_result_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: col %h/%h val %h/%h st %0d/%0d last %0d/%0d (exp/act)",
                             want.col, got.col, want.val, got.val,
                             want.st, got.st, want.lst, got.lst);
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         kind;
    logic [15:0]        col_index;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_ready;
    logic [15:0]        entry_index;
    logic signed [31:0] entry_value;
    logic [1:0]         status;
    logic               last;

    row_scoreboard sb;
    int            cycles;
    bit            hold_off;     // receiver long stall request

    sorted_sparse_row_accumulator_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .col_index(col_index), .value(value),
        .out_valid(out_valid), .out_ready(out_ready),
        .entry_index(entry_index), .entry_value(entry_value),
        .status(status), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: fail on a hung run.
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 600000)
            begin
                $display("** sorted_sparse_row_accumulator_top: FAILED **");
                $finish;
            end
        end
    end

    // Offer one request, hold it until accepted, then note it for prediction.
    // Valid stays up after acceptance; the next request replaces it or drops it for a gap, or drain drops it.
    task automatic send_request(input logic [2:0] k, input logic [15:0] c,
                                input logic signed [31:0] v);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        col_index <= c;
        value     <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_request(k, c, v);
    endtask

    // Drop valid and pause the sender until every predicted result has been seen.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // Random value: mostly small Q16.16, sometimes extremes or full range.
    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: return $urandom_range(0, 1) ? 32'sh0001_0000 : -32'sh0001_0000;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    // Receiver: random ready gaps, with one long hold-off when asked.
    initial
    begin
        int wait_n;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            wait_n = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 9);
            if (wait_n != 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            sb.check_result({entry_index, entry_value, status, last});
        end
    end

    initial
    begin
        logic [15:0] base;
        sb        = new();
        hold_off  = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        kind      <= KIND_ADD;
        col_index <= '0;
        value     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dump, extremes, saturation, remove of absent column.
        send_request(KIND_DUMP, 16'h0, 32'sh0);
        send_request(KIND_ADD, 16'hFFFF, 32'sh7FFF_FFFF);
        send_request(KIND_ADD, 16'hFFFF, 32'sh7FFF_FFFF);
        send_request(KIND_SUB, 16'h0000, 32'sh8000_0000);
        send_request(KIND_SUB, 16'h8000, 32'sh7FFF_FFFF);
        send_request(KIND_SUB, 16'h8000, 32'sh7FFF_FFFF);
        send_request(KIND_READ, 16'h1234, 32'sh0);
        send_request(KIND_READ, 16'hFFFF, 32'shFFFF_FFFF);
        send_request(KIND_SCALE, 16'h0, 32'sh0000_8000);
        send_request(KIND_SCALE, 16'h0, 32'sh8000_0000);
        send_request(KIND_DUMP, 16'h0, 32'sh0);
        send_request(KIND_REM, 16'h5555, 32'sh0);
        send_request(KIND_REM, 16'h1234, 32'sh0);
        send_request(3'd6, 16'hAAAA, 32'sh5555_5555);
        send_request(3'd7, 16'h5555, 32'shAAAA_AAAA);
        send_request(KIND_SCALE, 16'h0, 32'sh0);
        send_request(KIND_DUMP, 16'h0, 32'sh0);
        drain();

        // Fill the row past capacity while the receiver holds off.
        hold_off = 1;
        for (int i = 0; i < 68; i++)
            send_request(i[0] ? KIND_ADD : KIND_READ, 16'(i * 3 + 1), rand_value());
        send_request(KIND_SUB, 16'h0002, 32'sh1);
        send_request(KIND_DUMP, 16'h0, 32'sh0);
        drain();
        for (int i = 0; i < 66; i++)
            send_request(KIND_REM, 16'(i * 3 + 1), 32'sh0);
        drain();

        // Random: row-update streams over a small column window, mixed with noise.
        base = 16'($urandom());
        for (int i = 0; i < 20; i++)
        begin
            logic [2:0]  k;
            logic [15:0] c;
            int          pick;
            pick = $urandom_range(0, 19);
            if (pick < 8)       k = KIND_ADD;
            else if (pick < 12) k = KIND_SUB;
            else if (pick < 14) k = KIND_REM;
            else if (pick < 15) k = KIND_SCALE;
            else if (pick < 17) k = KIND_READ;
            else if (pick < 19) k = KIND_DUMP;
            else                k = 3'($urandom_range(6, 7));
            c = $urandom_range(0, 7) == 0 ? 16'($urandom()) : base + 16'($urandom_range(0, 40));
            send_request(k, c, rand_value());
            if (i == 10)
                drain();
        end
        drain();
        repeat (200) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("** sorted_sparse_row_accumulator_top: PASSED **");
        else
            $display("** sorted_sparse_row_accumulator_top: FAILED **");
        $finish;
    end

endmodule
